>>> hw/rtl/afcp_pkg.sv
// Package for the ASCII frame checksum parser.
// Holds character codes, field sizes, the result struct and the hex decode.
// No dependencies.
package afcp_pkg;

    localparam int unsigned MAX_FRAME_DEF = 32;
    localparam int unsigned CHAR_W        = 8;
    localparam int unsigned FILL_W        = 6;
    localparam int unsigned POS_W         = 5;
    localparam int unsigned PREFIX_W      = 16;
    localparam int unsigned ID_W          = 24;
    localparam int unsigned CHECK_W       = 16;

    localparam int unsigned PREFIX_SIZE = 2;
    localparam int unsigned ID_SIZE     = 3;
    localparam int unsigned DATA_SIZE   = 32;
    localparam int unsigned CHECK_SIZE  = 2;

    localparam logic [CHAR_W-1:0] CH_SEMI  = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_UPA   = 8'h41;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] HEX_TEN  = 8'd10;

    typedef enum logic [1:0] {
        FLD_PREFIX = 2'd0,
        FLD_ID     = 2'd1,
        FLD_DATA   = 2'd2,
        FLD_CHECK  = 2'd3
    } t_field;

    typedef struct packed {
        logic                frame_end;
        logic                frame_ok;
        logic                checksum_present;
        logic [PREFIX_W-1:0] prefix_chars;
        logic [ID_W-1:0]     id_chars;
        logic                data_valid;
        logic [CHAR_W-1:0]   data_char;
        logic [POS_W-1:0]    data_position;
    } t_result;

    function automatic logic [CHAR_W-1:0] hex_nibble(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] v;
        if (c >= CH_UPA) begin
            v = c - CH_UPA + HEX_TEN;
        end else begin
            v = c - CH_ZERO;
        end
        return v;
    endfunction

endpackage

>>> hw/rtl/afcp_in_stage.sv
// Input register of the ASCII frame checksum parser.
// Holds one character beat until the parser can advance it; uses afcp_pkg.
module afcp_in_stage (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [afcp_pkg::CHAR_W-1:0] i_char,
    output logic                       o_ready,
    input  logic                       i_adv,
    output logic                       o_valid,
    output logic [afcp_pkg::CHAR_W-1:0] o_char
);
    import afcp_pkg::*;

    logic              r_vld;
    logic [CHAR_W-1:0] r_char;

    assign o_ready = !r_vld || i_adv;
    assign o_valid = r_vld;
    assign o_char  = r_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_char <= i_char;
        end
    end

endmodule

>>> hw/rtl/afcp_parser.sv
// Frame state and per-character decode of the ASCII frame checksum parser.
// Sorts a character into its field, tracks XOR and length; uses afcp_pkg.
module afcp_parser #(
    parameter int unsigned MAX_FRAME = afcp_pkg::MAX_FRAME_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [afcp_pkg::CHAR_W-1:0] i_char,
    output afcp_pkg::t_result           o_result
);
    import afcp_pkg::*;

    localparam int unsigned LEN_W = $clog2(MAX_FRAME);
    localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(MAX_FRAME - 1);

    t_field              r_sel,    n_sel;
    logic [FILL_W-1:0]   r_fill,   n_fill;
    logic [LEN_W-1:0]    r_len,    n_len;
    logic [CHAR_W-1:0]   r_xor,    n_xor;
    logic [CHAR_W-1:0]   r_snap,   n_snap;
    logic                r_slash,  n_slash;
    logic                r_bad,    n_bad;
    logic [PREFIX_W-1:0] r_prefix, n_prefix;
    logic [ID_W-1:0]     r_id,     n_id;
    logic [CHECK_W-1:0]  r_check,  n_check;

    logic [FILL_W-1:0] size;
    logic [CHAR_W-1:0] hi_nib;
    logic [CHAR_W-1:0] lo_nib;
    logic [CHAR_W-1:0] want;

    always_comb begin
        case (r_sel)
            FLD_PREFIX: size = FILL_W'(PREFIX_SIZE);
            FLD_ID:     size = FILL_W'(ID_SIZE);
            FLD_DATA:   size = FILL_W'(DATA_SIZE);
            FLD_CHECK:  size = FILL_W'(CHECK_SIZE);
            default:    size = FILL_W'(CHECK_SIZE);
        endcase
    end

    assign hi_nib = hex_nibble(r_check[15:8]);
    assign lo_nib = hex_nibble(r_check[7:0]);
    assign want   = {hi_nib[3:0], 4'h0} + lo_nib;

    always_comb begin
        n_sel    = r_sel;
        n_fill   = r_fill;
        n_len    = r_len;
        n_xor    = r_xor ^ i_char;
        n_snap   = r_snap;
        n_slash  = r_slash;
        n_bad    = r_bad;
        n_prefix = r_prefix;
        n_id     = r_id;
        n_check  = r_check;
        o_result = '0;

        if (i_char == CH_SEMI) begin
            o_result.frame_end        = 1'b1;
            o_result.frame_ok         = !r_bad && (!r_slash || (want == r_snap));
            o_result.checksum_present = r_slash;
            o_result.prefix_chars     = r_prefix;
            o_result.id_chars         = r_id;
            n_sel   = FLD_PREFIX;
            n_fill  = '0;
            n_len   = '0;
            n_xor   = '0;
            n_snap  = '0;
            n_slash = 1'b0;
            n_bad   = 1'b0;
        end else begin
            if (r_len >= LEN_LAST) begin
                n_bad = 1'b1;
            end else begin
                n_len = r_len + 1'b1;
            end

            if (i_char == CH_DASH) begin
                n_sel  = FLD_ID;
                n_fill = '0;
            end else if (i_char == CH_COLON) begin
                n_sel  = FLD_DATA;
                n_fill = '0;
            end else if (i_char == CH_SLASH) begin
                n_sel   = FLD_CHECK;
                n_fill  = '0;
                n_slash = 1'b1;
                n_snap  = r_xor;
            end else if (r_fill >= size) begin
                n_bad = 1'b1;
            end else begin
                n_fill = r_fill + 1'b1;
                case (r_sel)
                    FLD_PREFIX: begin
                        if (r_fill[0]) begin
                            n_prefix[7:0] = i_char;
                        end else begin
                            n_prefix[15:8] = i_char;
                        end
                    end
                    FLD_ID: begin
                        case (r_fill[1:0])
                            2'd0:    n_id[23:16] = i_char;
                            2'd1:    n_id[15:8]  = i_char;
                            default: n_id[7:0]   = i_char;
                        endcase
                    end
                    FLD_DATA: begin
                        o_result.data_valid    = 1'b1;
                        o_result.data_char     = i_char;
                        o_result.data_position = r_fill[POS_W-1:0];
                    end
                    default: begin
                        if (r_fill[0]) begin
                            n_check[7:0] = i_char;
                        end else begin
                            n_check[15:8] = i_char;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel    <= FLD_PREFIX;
            r_fill   <= '0;
            r_len    <= '0;
            r_xor    <= '0;
            r_snap   <= '0;
            r_slash  <= 1'b0;
            r_bad    <= 1'b0;
            r_prefix <= '0;
            r_id     <= '0;
            r_check  <= '0;
        end else if (i_step) begin
            r_sel    <= n_sel;
            r_fill   <= n_fill;
            r_len    <= n_len;
            r_xor    <= n_xor;
            r_snap   <= n_snap;
            r_slash  <= n_slash;
            r_bad    <= n_bad;
            r_prefix <= n_prefix;
            r_id     <= n_id;
            r_check  <= n_check;
        end
    end

endmodule

>>> hw/rtl/afcp_out_stage.sv
// Result register of the ASCII frame checksum parser.
// Holds one result beat until the consumer takes it; uses afcp_pkg.
module afcp_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  afcp_pkg::t_result i_result,
    output logic              o_free,
    output logic              o_valid,
    input  logic              i_ready,
    output afcp_pkg::t_result o_result
);
    import afcp_pkg::*;

    logic    r_vld;
    t_result r_res;

    assign o_free   = !r_vld || i_ready;
    assign o_valid  = r_vld;
    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_free) begin
            r_vld <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_result;
        end
    end

endmodule

>>> hw/rtl/ascii_frame_checksum_parser_core.sv
// Top level of the ASCII frame checksum parser: input register, parser, result register.
// Depends on afcp_pkg, afcp_in_stage, afcp_parser and afcp_out_stage.
//
// Takes one ASCII character per beat of a frame "prefix-id:data/checksum;" and returns
// one result beat per character. Throughput is one character per cycle while i_ready
// stays high; a held result stalls the input. A result beat moves from the input
// register through the parser into the result register; the parser between them updates
// the frame state for each character as it moves on. Data characters are reported as
// they arrive; the semicolon beat carries frame_ok, checksum_present and the prefix and
// id stores. MAX_FRAME (8 to 64) bounds the frame length, semicolon included.
module ascii_frame_checksum_parser_core #(
    parameter int unsigned MAX_FRAME = afcp_pkg::MAX_FRAME_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [afcp_pkg::CHAR_W-1:0]   i_char_in,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_frame_end,
    output logic                          o_frame_ok,
    output logic                          o_checksum_present,
    output logic [afcp_pkg::PREFIX_W-1:0] o_prefix_chars,
    output logic [afcp_pkg::ID_W-1:0]     o_id_chars,
    output logic                          o_data_valid,
    output logic [afcp_pkg::CHAR_W-1:0]   o_data_char,
    output logic [afcp_pkg::POS_W-1:0]    o_data_position
);
    import afcp_pkg::*;

    logic              in_vld;
    logic [CHAR_W-1:0] in_char;
    logic              out_free;
    logic              step;
    t_result           parse_res;
    t_result           out_res;

    assign step = in_vld && out_free;

    afcp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_char  (i_char_in),
        .o_ready (o_ready),
        .i_adv   (out_free),
        .o_valid (in_vld),
        .o_char  (in_char)
    );

    afcp_parser #(
        .MAX_FRAME (MAX_FRAME)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_char   (in_char),
        .o_result (parse_res)
    );

    afcp_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_result (parse_res),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (out_res)
    );

    assign o_frame_end        = out_res.frame_end;
    assign o_frame_ok         = out_res.frame_ok;
    assign o_checksum_present = out_res.checksum_present;
    assign o_prefix_chars     = out_res.prefix_chars;
    assign o_id_chars         = out_res.id_chars;
    assign o_data_valid       = out_res.data_valid;
    assign o_data_char        = out_res.data_char;
    assign o_data_position    = out_res.data_position;

    a_end_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_end |-> !o_data_valid)
        else $error("frame end beat also carries a data character");

    a_ok_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_frame_ok || o_checksum_present) |-> o_frame_end)
        else $error("frame status outside a frame end beat");

    a_quiet_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data_valid |-> (o_data_char == '0) && (o_data_position == '0))
        else $error("data fields set without a data character");

    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_vld && !o_ready |-> o_valid && !i_ready)
        else $error("input held while result stage is free");

endmodule

>>> test/tb_ascii_frame_checksum_parser_core.sv
// Testbench for ascii_frame_checksum_parser_core: sends character frames, predicts each
// result beat with a local frame parser and checks every field in order.
// Depends on afcp_pkg and the parser RTL.
`timescale 1ns / 1ps

module tb_ascii_frame_checksum_parser_core;
    import afcp_pkg::*;

    localparam int unsigned FRAME_LIMIT = MAX_FRAME_DEF;
    localparam int          STALL_LIMIT = 1000;
    localparam int          TAIL_CYCLES = 10;
    localparam int          PHASE_CHARS = 400;
    localparam int          PRINT_CAP   = 50;

    localparam int FRM_WELL  = 0;
    localparam int FRM_LONG  = 1;
    localparam int FRM_OVER  = 2;
    localparam int FRM_SEPS  = 3;
    localparam int FRM_NOISE = 4;

    localparam int CHK_NONE  = 0;
    localparam int CHK_GOOD  = 1;
    localparam int CHK_HEX   = 2;
    localparam int CHK_JUNK  = 3;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic [CHAR_W-1:0]   i_char_in = '0;
    logic                i_ready = 1'b0;
    logic                o_ready;
    logic                o_valid;
    logic                o_frame_end;
    logic                o_frame_ok;
    logic                o_checksum_present;
    logic [PREFIX_W-1:0] o_prefix_chars;
    logic [ID_W-1:0]     o_id_chars;
    logic                o_data_valid;
    logic [CHAR_W-1:0]   o_data_char;
    logic [POS_W-1:0]    o_data_position;

    ascii_frame_checksum_parser_core #(
        .MAX_FRAME(FRAME_LIMIT)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_char_in          (i_char_in),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_frame_end        (o_frame_end),
        .o_frame_ok         (o_frame_ok),
        .o_checksum_present (o_checksum_present),
        .o_prefix_chars     (o_prefix_chars),
        .o_id_chars         (o_id_chars),
        .o_data_valid       (o_data_valid),
        .o_data_char        (o_data_char),
        .o_data_position    (o_data_position)
    );

    always #2 i_clk = ~i_clk;

    // frame parser state
    t_field              cur_field;
    logic [FILL_W-1:0]   fill_count;
    logic [FILL_W-1:0]   frame_len;
    logic [CHAR_W-1:0]   xor_acc;
    logic [CHAR_W-1:0]   xor_snap;
    logic                has_check;
    logic                frame_err;
    logic [PREFIX_W-1:0] prefix_reg;
    logic [ID_W-1:0]     id_reg;
    logic [CHECK_W-1:0]  check_reg;

    t_result           expected_beats[$];
    logic [CHAR_W-1:0] frame_buf[$];
    int                mismatch_count = 0;
    int                chars_sent     = 0;
    int                stall_cycles   = 0;
    int                src_idle_pct   = 0;
    int                snk_idle_pct   = 0;

    function automatic logic [CHAR_W-1:0] hex_val(input logic [CHAR_W-1:0] c);
        return (c >= CH_UPA) ? c - CH_UPA + HEX_TEN : c - CH_ZERO;
    endfunction

    function automatic logic [CHAR_W-1:0] hex_digit(input logic [3:0] n);
        return (n < 4'd10) ? CH_ZERO + n : CH_UPA + n - 4'd10;
    endfunction

    function automatic logic is_sep(input logic [CHAR_W-1:0] c);
        return c == CH_SEMI || c == CH_DASH || c == CH_COLON || c == CH_SLASH;
    endfunction

    task automatic clear_frame_state();
        cur_field  = FLD_PREFIX;
        fill_count = '0;
        frame_len  = '0;
        xor_acc    = '0;
        xor_snap   = '0;
        has_check  = 1'b0;
        frame_err  = 1'b0;
    endtask

    task automatic parse_char(input logic [CHAR_W-1:0] c);
        t_result     r;
        logic [7:0]  hi;
        logic [7:0]  want;
        int unsigned lim;
        r = '0;
        if (c == CH_SEMI) begin
            r.frame_end = 1'b1;
            r.frame_ok  = !frame_err;
            if (has_check) begin
                hi   = hex_val(check_reg[15:8]);
                want = {hi[3:0], 4'h0} + hex_val(check_reg[7:0]);
                if (want != xor_snap) begin
                    r.frame_ok = 1'b0;
                end
            end
            r.checksum_present = has_check;
            r.prefix_chars     = prefix_reg;
            r.id_chars         = id_reg;
            clear_frame_state();
        end else begin
            if (frame_len >= FRAME_LIMIT - 1) begin
                frame_err = 1'b1;
            end else begin
                frame_len = frame_len + 1'b1;
            end
            if (c == CH_DASH) begin
                cur_field  = FLD_ID;
                fill_count = '0;
            end else if (c == CH_COLON) begin
                cur_field  = FLD_DATA;
                fill_count = '0;
            end else if (c == CH_SLASH) begin
                cur_field  = FLD_CHECK;
                fill_count = '0;
                has_check  = 1'b1;
                xor_snap   = xor_acc;
            end else begin
                case (cur_field)
                    FLD_PREFIX: lim = PREFIX_SIZE;
                    FLD_ID:     lim = ID_SIZE;
                    FLD_DATA:   lim = DATA_SIZE;
                    default:    lim = CHECK_SIZE;
                endcase
                if (fill_count >= lim) begin
                    frame_err = 1'b1;
                end else begin
                    case (cur_field)
                        FLD_PREFIX: prefix_reg[8*(PREFIX_SIZE-1-fill_count) +: 8] = c;
                        FLD_ID:     id_reg[8*(ID_SIZE-1-fill_count) +: 8] = c;
                        FLD_DATA: begin
                            r.data_valid    = 1'b1;
                            r.data_char     = c;
                            r.data_position = fill_count[POS_W-1:0];
                        end
                        default:    check_reg[8*(CHECK_SIZE-1-fill_count) +: 8] = c;
                    endcase
                    fill_count = fill_count + 1'b1;
                end
            end
            xor_acc = xor_acc ^ c;
        end
        expected_beats.push_back(r);
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_beats.size() == 0) begin
                report_mismatch("result beat with nothing expected");
            end else begin
                e = expected_beats.pop_front();
                check_field("frame_end", 32'(o_frame_end), 32'(e.frame_end));
                check_field("frame_ok", 32'(o_frame_ok), 32'(e.frame_ok));
                check_field("checksum_present", 32'(o_checksum_present),
                            32'(e.checksum_present));
                check_field("prefix_chars", 32'(o_prefix_chars), 32'(e.prefix_chars));
                check_field("id_chars", 32'(o_id_chars), 32'(e.id_chars));
                check_field("data_valid", 32'(o_data_valid), 32'(e.data_valid));
                check_field("data_char", 32'(o_data_char), 32'(e.data_char));
                check_field("data_position", 32'(o_data_position),
                            32'(e.data_position));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_char(input logic [CHAR_W-1:0] c);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_char_in <= c;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        parse_char(c);
        chars_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_buf[k]) begin
            send_char(frame_buf[k]);
        end
        frame_buf.delete();
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_beats.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            frame_buf.push_back(s[k]);
        end
    endtask

    task automatic push_plain(input int n);
        logic [CHAR_W-1:0] c;
        for (int k = 0; k < n; k++) begin
            do begin
                c = CHAR_W'($urandom_range(0, 255));
            end while (is_sep(c));
            frame_buf.push_back(c);
        end
    endtask

    // slash plus two checksum characters, then any extra ones
    task automatic push_checksum(input int mode, input int extra);
        logic [CHAR_W-1:0] x;
        x = '0;
        foreach (frame_buf[k]) begin
            x ^= frame_buf[k];
        end
        frame_buf.push_back(CH_SLASH);
        case (mode)
            CHK_GOOD: begin
                frame_buf.push_back(hex_digit(x[7:4]));
                frame_buf.push_back(hex_digit(x[3:0]));
            end
            CHK_HEX: begin
                frame_buf.push_back(hex_digit(4'($urandom_range(0, 15))));
                frame_buf.push_back(hex_digit(4'($urandom_range(0, 15))));
            end
            default: begin
                frame_buf.push_back($urandom_range(0, 1)
                                    ? 8'h61 + CHAR_W'($urandom_range(0, 5))
                                    : 8'h47 + CHAR_W'($urandom_range(0, 20)));
                push_plain(1);
            end
        endcase
        push_plain(extra);
    endtask

    task automatic build_frame(input int kind);
        int pre_n;
        int id_n;
        int dat_n;
        int chk_mode;
        int chk_extra;
        int sel;
        pre_n     = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : PREFIX_SIZE;
        id_n      = $urandom_range(0, ID_SIZE);
        dat_n     = $urandom_range(0, 14);
        sel       = $urandom_range(0, 9);
        chk_mode  = (sel < 2) ? CHK_NONE : (sel < 8) ? CHK_GOOD : (sel < 9) ? CHK_HEX : CHK_JUNK;
        chk_extra = 0;
        case (kind)
            FRM_LONG: begin
                pre_n = PREFIX_SIZE;
                id_n  = ID_SIZE;
                dat_n = $urandom_range(20, 35);
            end
            FRM_OVER: begin
                sel = $urandom_range(0, 2);
                if (sel == 0) begin
                    pre_n = PREFIX_SIZE + $urandom_range(1, 2);
                end else if (sel == 1) begin
                    id_n = ID_SIZE + $urandom_range(1, 2);
                end else begin
                    chk_mode  = CHK_GOOD;
                    chk_extra = $urandom_range(1, 2);
                end
            end
            default: ;
        endcase
        if (kind == FRM_SEPS) begin
            repeat ($urandom_range(1, 12)) begin
                sel = $urandom_range(0, 3);
                if (sel == 0) frame_buf.push_back(CH_DASH);
                else if (sel == 1) frame_buf.push_back(CH_COLON);
                else if (sel == 2) frame_buf.push_back(CH_SLASH);
                else push_plain(1);
            end
        end else if (kind == FRM_NOISE) begin
            repeat ($urandom_range(0, 10)) begin
                frame_buf.push_back(CHAR_W'($urandom_range(0, 255)));
            end
        end else begin
            push_plain(pre_n);
            frame_buf.push_back(CH_DASH);
            push_plain(id_n);
            frame_buf.push_back(CH_COLON);
            push_plain(dat_n);
            if (chk_mode != CHK_NONE) begin
                push_checksum(chk_mode, chk_extra);
            end
        end
        frame_buf.push_back(CH_SEMI);
    endtask

    task automatic test_checksum_frame();
        push_text("AB-X1Z:");
        frame_buf.push_back(8'h00);
        frame_buf.push_back(8'hFF);
        push_checksum(CHK_GOOD, 0);
        frame_buf.push_back(CH_SEMI);
        frame_buf.push_back(CH_SEMI);
        send_frame();
    endtask

    task automatic test_field_overflow();
        push_text("PQR-;");
        send_frame();
    endtask

    task automatic test_repeated_separators();
        push_text("-:/-:A//41;");
        send_frame();
        wait_drained();
    endtask

    task automatic test_random_phase(input int src_pct, input int snk_pct);
        int stop_at;
        int r;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        stop_at = chars_sent + PHASE_CHARS;
        while (chars_sent < stop_at) begin
            r = $urandom_range(0, 99);
            build_frame(r < 55 ? FRM_WELL : r < 67 ? FRM_LONG : r < 79 ? FRM_OVER :
                        r < 89 ? FRM_SEPS : FRM_NOISE);
            send_frame();
        end
        wait_drained();
    endtask

    initial begin
        clear_frame_state();
        prefix_reg   = '0;
        id_reg       = '0;
        check_reg    = '0;
        src_idle_pct = 22;
        snk_idle_pct = 69;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_checksum_frame();
        test_field_overflow();
        test_repeated_separators();
        test_random_phase(22, 69);
        test_random_phase(69, 22);
        test_random_phase(0, 0);

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_beats.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
